@@ src/ntl_pkg.sv @@
// Shared types and constants for the top-N largest key tracker.
`timescale 1ns / 1ps
package ntl_pkg;

  // Number of kept entries (one cell each)
  localparam int unsigned Depth = 16;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned PldW  = 32;
  localparam int unsigned RankW = 4;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Input transaction
  typedef struct packed {
    logic                    operation;
    logic signed [KeyW-1:0]  key;
    logic        [PldW-1:0]  payload;
    logic        [RankW-1:0] rank;
  } ntl_req_t;

  // Result transaction
  typedef struct packed {
    logic                   accepted;
    logic signed [KeyW-1:0] key_out;
    logic        [PldW-1:0] payload_out;
  } ntl_rsp_t;

  // One stored entry
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic        [PldW-1:0] payload;
  } ntl_entry_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic                   insert;
    logic signed [KeyW-1:0] key;
    logic        [PldW-1:0] payload;
  } ntl_bcast_t;

  // Reset value of an entry: key -1, payload all ones
  localparam ntl_entry_t EntryReset = '{key: '1, payload: '1};

endpackage

@@ src/top_n_largest_tracker.sv @@
// Top level: chain of sorted cells, rank read mux and result register.
//   Result: the strobe rises in the cycle after the transaction is taken.
//   Throughput: one transaction per cycle; busy stays low, as each cell
//   compares and shifts in the same cycle the transaction is taken.
//   Reset: all entries return to key -1 and payload all ones at once.
//   The receiver cannot stall; each result shows for a single cycle.
`timescale 1ns / 1ps
module top_n_largest_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ntl_pkg::ntl_req_t req_i,
  output logic             done_o,
  output ntl_pkg::ntl_rsp_t rsp_o
);
  import ntl_pkg::*;

  ntl_bcast_t bcast;
  ntl_entry_t entries [Depth];
  logic       le      [Depth];
  logic       take;
  ntl_rsp_t   rsp_d, rsp_q;
  logic       done_q;

  assign busy = 1'b0;
  assign take = start && !busy;

  // Broadcast the insert to every cell; kept only if the smallest entry is not above it
  always_comb begin
    bcast.insert  = take && (req_i.operation == OP_INSERT);
    bcast.key     = req_i.key;
    bcast.payload = req_i.payload;
  end

  // Cell chain; the top cell has no upper neighbor
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    ntl_entry_t up_entry;
    logic       up_le;
    if (g == Depth - 1) begin : g_last
      assign up_entry = EntryReset;
      assign up_le    = 1'b0;
    end else begin : g_mid
      assign up_entry = entries[g+1];
      assign up_le    = le[g+1];
    end
    ntl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .bcast_i    (bcast),
      .up_entry_i (up_entry),
      .up_le_i    (up_le),
      .entry_o    (entries[g]),
      .le_o       (le[g])
    );
  end

  // Result: rank select for reads, accept flag for inserts
  always_comb begin
    rsp_d = '0;
    if (req_i.operation == OP_READ) begin
      for (int i = 0; i < Depth; i++) begin
        if (32'(req_i.rank) == 32'(i)) begin
          rsp_d.key_out     = entries[i].key;
          rsp_d.payload_out = entries[i].payload;
        end
      end
    end else begin
      rsp_d.accepted = le[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ src/ntl_cell.sv @@
// One cell of the sorted chain: holds one entry and compares it with the new key.
`timescale 1ns / 1ps
module ntl_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ntl_pkg::ntl_bcast_t bcast_i,
  input  ntl_pkg::ntl_entry_t up_entry_i,
  input  logic               up_le_i,
  output ntl_pkg::ntl_entry_t entry_o,
  output logic               le_o
);
  import ntl_pkg::*;

  ntl_entry_t entry_q, entry_d;

  // Kept key is not above the new key
  assign le_o = ($signed(entry_q.key) <= $signed(bcast_i.key));

  // Shift down from the upper neighbor, or take the new entry at the boundary
  always_comb begin
    entry_d = entry_q;
    if (bcast_i.insert && le_o) begin
      if (up_le_i) begin
        entry_d = up_entry_i;
      end else begin
        entry_d.key     = bcast_i.key;
        entry_d.payload = bcast_i.payload;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= EntryReset;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ bench/ntl_checker.sv @@
// Checker for the top-N tracker: models the kept table and compares each result.
`timescale 1ns / 1ps
module ntl_checker
  import ntl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  ntl_req_t    req_i,
  input  logic        done_i,
  input  ntl_rsp_t    rsp_i,
  output int unsigned err_count_o,
  output int unsigned open_count_o
);

  // Modeled table, rank 0 holds the smallest kept key
  logic signed [KeyW-1:0] kept_key [Depth];
  logic        [PldW-1:0] kept_pld [Depth];

  // Results predicted but not yet seen, oldest first
  ntl_rsp_t    rsp_due_q [$];
  int unsigned err_cnt;
  int unsigned open_cnt;

  assign err_count_o  = err_cnt;
  assign open_count_o = open_cnt;

  // Apply one transaction to the modeled table and return its result
  function automatic ntl_rsp_t table_step(ntl_req_t req);
    ntl_rsp_t         rsp;
    int unsigned      n_le;
    logic [RankW-1:0] slot;
    rsp  = '0;
    n_le = 0;
    if (req.operation == OP_READ) begin
      if (req.rank < Depth) begin
        rsp.key_out     = kept_key[req.rank];
        rsp.payload_out = kept_pld[req.rank];
      end
      return rsp;
    end
    // below the smallest kept key: rejected, table untouched
    if ($signed(req.key) < $signed(kept_key[0])) begin
      return rsp;
    end
    // ties go above every equal key
    for (int i = 0; i < Depth; i++) begin
      if ($signed(kept_key[i]) <= $signed(req.key)) begin
        n_le++;
      end
    end
    slot = RankW'(n_le - 1);
    for (int i = 0; i < slot; i++) begin
      kept_key[i] = kept_key[i+1];
      kept_pld[i] = kept_pld[i+1];
    end
    kept_key[slot] = req.key;
    kept_pld[slot] = req.payload;
    rsp.accepted   = 1'b1;
    return rsp;
  endfunction

  // Compare results first (they belong to earlier transactions), then predict
  always @(posedge clk_i or negedge rst_ni) begin
    ntl_rsp_t due;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        kept_key[i] = EntryReset.key;
        kept_pld[i] = EntryReset.payload;
      end
      rsp_due_q.delete();
      err_cnt  = 0;
      open_cnt = 0;
    end else begin
      if (done_i === 1'b1) begin
        if (rsp_due_q.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          err_cnt++;
        end else begin
          due = rsp_due_q.pop_front();
          if (rsp_i.accepted !== due.accepted) begin
            $error("accepted: expected %0d, actual %0d", due.accepted, rsp_i.accepted);
            err_cnt++;
          end
          if (rsp_i.key_out !== due.key_out) begin
            $error("key_out: expected %0d, actual %0d", due.key_out, rsp_i.key_out);
            err_cnt++;
          end
          if (rsp_i.payload_out !== due.payload_out) begin
            $error("payload_out: expected %h, actual %h", due.payload_out,
                   rsp_i.payload_out);
            err_cnt++;
          end
        end
      end
      if (start_i && !busy_i) begin
        rsp_due_q.push_back(table_step(req_i));
      end
      open_cnt = rsp_due_q.size();
    end
  end

endmodule

@@ bench/top_n_largest_tracker_tb.sv @@
// Testbench top for the top-N tracker: drives transactions and reports the verdict.
`timescale 1ns / 1ps
module top_n_largest_tracker_tb;
  import ntl_pkg::*;

  localparam int unsigned RandItems = 1850;
  localparam int unsigned TailWait  = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  ntl_req_t    req_i = '0;
  logic        busy;
  logic        done_o;
  ntl_rsp_t    rsp_o;
  int unsigned err_count;
  int unsigned open_count;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  top_n_largest_tracker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  ntl_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .rsp_i        (rsp_o),
    .err_count_o  (err_count),
    .open_count_o (open_count)
  );

  // Present one transaction, hold until taken, then idle for the given gap; with no gap, start stays high
  task automatic send_req(input ntl_req_t req, input int unsigned gap);
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic ntl_req_t mk_req(logic op, logic [KeyW-1:0] key,
                                      logic [PldW-1:0] pld, logic [RankW-1:0] rank);
    ntl_req_t r;
    r.operation = op;
    r.key       = key;
    r.payload   = pld;
    r.rank      = rank;
    return r;
  endfunction

  // Run limit
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    ntl_req_t    req;
    int          ladder;
    int unsigned wait_cnt;
    logic        burst;
    ladder = -60;
    burst  = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset contents, extremes, equal-to-smallest, ties
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd0), 0);
    send_req(mk_req(OP_READ, 32'hffff_ffff, 32'hffff_ffff, 4'd15), 1);
    send_req(mk_req(OP_INSERT, 32'h8000_0000, 32'h1234_5678, 4'd0), 0);  // below smallest
    send_req(mk_req(OP_INSERT, 32'hffff_ffff, 32'h0, 4'd15), 2);         // equal to smallest
    send_req(mk_req(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 4'd0), 0);
    send_req(mk_req(OP_INSERT, 32'h0, 32'h0, 4'd7), 0);
    send_req(mk_req(OP_INSERT, 32'd5, 32'haaaa_aaaa, 4'd0), 3);
    send_req(mk_req(OP_INSERT, 32'd5, 32'h5555_5555, 4'd0), 0);          // tie goes above
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd15), 0);
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd14), 0);
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd13), 1);
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd12), 0);
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd11), 0);
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd0), 0);
    send_req(mk_req(OP_INSERT, 32'hffff_fffe, 32'h0, 4'd0), 0);          // below smallest
    send_req(mk_req(OP_INSERT, 32'h7fff_ffff, 32'h0bad_cafe, 4'd3), 0);  // tie at the top
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd15), 0);
    send_req(mk_req(OP_READ, 32'h0, 32'h0, 4'd10), 4);

    // Random: half the keys follow a climbing key ladder so inserts keep evicting
    for (int i = 0; i < RandItems; i++) begin
      if (i % 150 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      req.operation = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_READ;
      req.payload   = $urandom();
      req.rank      = RankW'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          ladder++;
          req.key = ladder + int'($urandom_range(0, 16)) - 8;
        end
        5, 6: req.key = $urandom();
        7: begin
          case ($urandom_range(0, 3))
            0: req.key = 32'h8000_0000;
            1: req.key = 32'h7fff_ffff;
            2: req.key = 32'hffff_ffff;
            default: req.key = 32'h0;
          endcase
        end
        default: req.key = int'($urandom_range(0, 40)) - 20;
      endcase
      send_req(req, burst ? 0 : $urandom_range(0, 19));
    end

    start <= 1'b0;
    @(posedge clk_i);

    // Drain outstanding results, then wait on for stray strobes
    wait_cnt = 0;
    @(negedge clk_i);
    while (open_count != 0 && wait_cnt < TailWait) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (4) @(negedge clk_i);

    if (err_count == 0 && open_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
